FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared check forms for the clock replacement block, clocked on clk,
// quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant that holds at every edge out of reset
`define CPR_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// same-cycle implication
`define CPR_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPR_IMPLY_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// shared widths, codes and types of the clock page replacement block
// ----------------------------------------------------------------------------
package cpr_pkg;

  // payload widths
  localparam int PAGE_W   = 27;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // default number of page frames
  localparam int FRAMES_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

  // link store write enables
  typedef struct packed {
    logic wr_next;
    logic wr_prev;
  } cpr_link_wr_t;

endpackage

FILE: hw/rtl/cpr_links.sv
// ----------------------------------------------------------------------------
// cpr_links
// successor and predecessor links of the ring: slot links in two memories,
// the sentinel's links in registers, one registered read of a node per cycle
// ----------------------------------------------------------------------------
module cpr_links
  import cpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int NW     = $clog2(FRAMES + 1),
  parameter int SW     = $clog2(FRAMES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [NW-1:0] rd_node,
  input  cpr_link_wr_t  wr,
  input  logic [NW-1:0] next_node,
  input  logic [NW-1:0] next_val,
  input  logic [NW-1:0] prev_node,
  input  logic [NW-1:0] prev_val,
  output logic [NW-1:0] next_q,
  output logic [NW-1:0] prev_q
);

  localparam logic [NW-1:0] SENT = NW'(FRAMES);

  logic [NW-1:0] next_mem [FRAMES];
  logic [NW-1:0] prev_mem [FRAMES];
  logic [NW-1:0] sent_next_r;
  logic [NW-1:0] sent_prev_r;
  logic [NW-1:0] next_rd_r;
  logic [NW-1:0] prev_rd_r;
  logic          rd_sent_r;

  // sentinel links, self loop after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_next_r <= SENT;
      sent_prev_r <= SENT;
    end else begin
      if (wr.wr_next && next_node == SENT) begin
        sent_next_r <= next_val;
      end
      if (wr.wr_prev && prev_node == SENT) begin
        sent_prev_r <= prev_val;
      end
    end
  end

  // slot link memories, one write and one read each
  always_ff @(posedge clk) begin
    if (wr.wr_next && next_node != SENT) begin
      next_mem[next_node[SW-1:0]] <= next_val;
    end
    if (wr.wr_prev && prev_node != SENT) begin
      prev_mem[prev_node[SW-1:0]] <= prev_val;
    end
    next_rd_r <= next_mem[rd_node[SW-1:0]];
    prev_rd_r <= prev_mem[rd_node[SW-1:0]];
    rd_sent_r <= (rd_node == SENT);
  end

  // sentinel reads come from the registers
  assign next_q = rd_sent_r ? sent_next_r : next_rd_r;
  assign prev_q = rd_sent_r ? sent_prev_r : prev_rd_r;

endmodule

FILE: hw/rtl/cpr_tags.sv
// ----------------------------------------------------------------------------
// cpr_tags
// page tag memory with a registered read and the shared page compare unit
// ----------------------------------------------------------------------------
module cpr_tags
  import cpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int SW     = $clog2(FRAMES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SW-1:0]     wr_slot,
  input  logic [PAGE_W-1:0] wr_tag,
  input  logic [SW-1:0]     rd_slot,
  input  logic [PAGE_W-1:0] cmp_page,
  output logic [PAGE_W-1:0] tag_q,
  output logic              hit
);

  logic [PAGE_W-1:0] tag_mem [FRAMES];
  logic [PAGE_W-1:0] tag_rd_r;

  // tag memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_slot] <= wr_tag;
    end
    tag_rd_r <= tag_mem[rd_slot];
  end

  // compare of the tag read last cycle
  assign tag_q = tag_rd_r;
  assign hit   = (tag_rd_r == cmp_page);

endmodule

FILE: hw/rtl/clock_page_replacement_top.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_top: insert scans for the lowest free slot, then links;
// access compares every slot's tag; victim walks the ring, one link memory read
// per node visited, then unlinks; status-only answers are given from idle
// one item at a time, busy high until the result strobe; results cannot stall
// synchronous active-low reset empties the ring and parks the hand on sentinel
// ----------------------------------------------------------------------------
module clock_page_replacement_top
  import cpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [PAGE_W-1:0]   in_page_number,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_victim_valid,
  output logic [PAGE_W-1:0]   out_victim_page
);

`include "assert_macros.svh"

  localparam int NW = $clog2(FRAMES + 1);
  localparam int SW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [NW-1:0] SENT = NW'(FRAMES);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FREE    = 4'd1;
  localparam logic [3:0] S_INS_A   = 4'd2;
  localparam logic [3:0] S_INS_B   = 4'd3;
  localparam logic [3:0] S_ACC     = 4'd4;
  localparam logic [3:0] S_ACC_END = 4'd5;
  localparam logic [3:0] S_V_WAIT  = 4'd6;
  localparam logic [3:0] S_V_STEP  = 4'd7;
  localparam logic [3:0] S_V_UNL   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [NW-1:0]       hand_r, hand_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [FRAMES-1:0]   ref_bit_r, ref_bit_nxt;
  logic [FRAMES-1:0]   slot_used_r, slot_used_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [SW-1:0]       scan_r, scan_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [NW-1:0]       after_r, after_nxt;
  logic [NW-1:0]       pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [SW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_vv_r, out_vv_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;

  // link store and tag store hookup
  cpr_link_wr_t        lk_wr;
  logic [NW-1:0]       lk_rd_node;
  logic [NW-1:0]       lk_next_node, lk_next_val, lk_prev_node, lk_prev_val;
  logic [NW-1:0]       next_q, prev_q;
  logic                tag_wr;
  logic [SW-1:0]       tag_rd_slot;
  logic [PAGE_W-1:0]   tag_q;
  logic                tag_hit;
  logic [SW-1:0]       pos_slot;
  logic                hit_now;

  cpr_links #(
    .FRAMES (FRAMES),
    .NW     (NW),
    .SW     (SW)
  ) u_links (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_node   (lk_rd_node),
    .wr        (lk_wr),
    .next_node (lk_next_node),
    .next_val  (lk_next_val),
    .prev_node (lk_prev_node),
    .prev_val  (lk_prev_val),
    .next_q    (next_q),
    .prev_q    (prev_q)
  );

  cpr_tags #(
    .FRAMES (FRAMES),
    .SW     (SW)
  ) u_tags (
    .clk      (clk),
    .wr_en    (tag_wr),
    .wr_slot  (slot_r),
    .wr_tag   (page_r),
    .rd_slot  (tag_rd_slot),
    .cmp_page (page_r),
    .tag_q    (tag_q),
    .hit      (tag_hit)
  );

  assign pos_slot    = pos_r[SW-1:0];
  assign tag_rd_slot = (state_r == S_ACC) ? scan_r : pos_slot;
  assign lk_rd_node  = (state_r == S_IDLE || state_r == S_FREE) ? hand_r : pos_r;
  assign hit_now     = cmp_vld_r && tag_hit && slot_used_r[cmp_idx_r];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    hand_nxt       = hand_r;
    count_nxt      = count_r;
    ref_bit_nxt    = ref_bit_r;
    slot_used_nxt  = slot_used_r;
    page_nxt       = page_r;
    scan_nxt       = scan_r;
    slot_nxt       = slot_r;
    after_nxt      = after_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_vv_nxt     = out_vv_r;
    out_page_nxt   = out_page_r;
    lk_wr          = '0;
    lk_next_node   = pos_r;
    lk_next_val    = pos_r;
    lk_prev_node   = pos_r;
    lk_prev_val    = pos_r;
    tag_wr         = 1'b0;

    // access compare, one tag per cycle
    if (hit_now) begin
      ref_bit_nxt[cmp_idx_r] = 1'b1;
      found_nxt              = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          page_nxt = in_page_number;
          unique case (in_operation)
            OP_INSERT: begin
              if (count_r == CW'(FRAMES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FULL;
                out_vv_nxt     = 1'b0;
                out_page_nxt   = '0;
              end else begin
                scan_nxt  = '0;
                state_nxt = S_FREE;
              end
            end
            OP_ACCESS: begin
              scan_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = S_ACC;
            end
            OP_VICTIM: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
                out_vv_nxt     = 1'b0;
                out_page_nxt   = '0;
              end else begin
                state_nxt = S_V_WAIT;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
              out_vv_nxt     = 1'b0;
              out_page_nxt   = '0;
            end
          endcase
        end
      end

      // lowest free slot
      S_FREE: begin
        if (!slot_used_r[scan_r]) begin
          slot_nxt  = scan_r;
          state_nxt = S_INS_A;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // new node links to hand and its successor
      S_INS_A: begin
        after_nxt            = next_q;
        lk_wr.wr_next        = 1'b1;
        lk_next_node         = NW'(slot_r);
        lk_next_val          = next_q;
        lk_wr.wr_prev        = 1'b1;
        lk_prev_node         = NW'(slot_r);
        lk_prev_val          = hand_r;
        tag_wr               = 1'b1;
        state_nxt            = S_INS_B;
      end

      // neighbors point at the new node, hand moves onto it
      S_INS_B: begin
        lk_wr.wr_next  = 1'b1;
        lk_next_node   = hand_r;
        lk_next_val    = NW'(slot_r);
        lk_wr.wr_prev  = 1'b1;
        lk_prev_node   = after_r;
        lk_prev_val    = NW'(slot_r);
        ref_bit_nxt[slot_r]   = 1'b1;
        slot_used_nxt[slot_r] = 1'b1;
        hand_nxt       = NW'(slot_r);
        count_nxt      = count_r + 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_vv_nxt     = 1'b0;
        out_page_nxt   = '0;
        state_nxt      = S_IDLE;
      end

      // issue tag reads for every slot
      S_ACC: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_r;
        if (scan_r == SW'(FRAMES - 1)) begin
          state_nxt = S_ACC_END;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_ACC_END: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = (found_r || hit_now) ? STAT_OK : STAT_ABSENT;
        out_vv_nxt     = 1'b0;
        out_page_nxt   = '0;
        state_nxt      = S_IDLE;
      end

      // successor of the node read last cycle
      S_V_WAIT: begin
        pos_nxt   = next_q;
        state_nxt = S_V_STEP;
      end

      // skip sentinel, give a second chance or take the victim
      S_V_STEP: begin
        if (pos_r == SENT) begin
          state_nxt = S_V_WAIT;
        end else if (!ref_bit_r[pos_slot]) begin
          state_nxt = S_V_UNL;
        end else begin
          ref_bit_nxt[pos_slot] = 1'b0;
          state_nxt             = S_V_WAIT;
        end
      end

      // unlink victim, hand on its predecessor
      S_V_UNL: begin
        lk_wr.wr_next           = 1'b1;
        lk_next_node            = prev_q;
        lk_next_val             = next_q;
        lk_wr.wr_prev           = 1'b1;
        lk_prev_node            = next_q;
        lk_prev_val             = prev_q;
        slot_used_nxt[pos_slot] = 1'b0;
        ref_bit_nxt[pos_slot]   = 1'b0;
        hand_nxt                = prev_q;
        count_nxt               = count_r - 1'b1;
        out_valid_nxt           = 1'b1;
        out_status_nxt          = STAT_OK;
        out_vv_nxt              = 1'b1;
        out_page_nxt            = tag_q;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hand_r      <= SENT;
      count_r     <= '0;
      ref_bit_r   <= '0;
      slot_used_r <= '0;
      found_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hand_r      <= hand_nxt;
      count_r     <= count_nxt;
      ref_bit_r   <= ref_bit_nxt;
      slot_used_r <= slot_used_nxt;
      found_r     <= found_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    scan_r       <= scan_nxt;
    slot_r       <= slot_nxt;
    after_r      <= after_nxt;
    pos_r        <= pos_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    out_status_r <= out_status_nxt;
    out_vv_r     <= out_vv_nxt;
    out_page_r   <= out_page_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_page  = out_page_r;

  // checks
  `CPR_CHECK(a_count_matches_used, $countones(slot_used_r) == count_r, "count mismatch")
  `CPR_CHECK(a_ref_only_on_used, (ref_bit_r & ~slot_used_r) == '0, "ref bit on free slot")
  `CPR_IMPLY(a_result_when_idle, out_valid_r, !busy, "result while busy")
  `CPR_IMPLY(a_victim_is_result, out_vv_r && out_valid_r, out_status_r == STAT_OK, "bad victim status")
  `CPR_IMPLY_NEXT(a_access_goes_busy, start && !busy && in_operation == OP_ACCESS, busy, "access not started")

endmodule

FILE: tb/clock_page_replacement_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_page_replacement_checker
// watches the command and answer beats of the clock replacement block, keeps
// its own ring of resident pages with reference bits and a hand, and compares
// every answer beat field by field with the oldest predicted answer
// ----------------------------------------------------------------------------
module clock_page_replacement_checker
  import cpr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [PAGE_W-1:0]   in_page_number,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic                out_victim_valid,
  input  logic [PAGE_W-1:0]   out_victim_page,
  output int                  mismatch_count,
  output int                  answers_due
);

  localparam int HEAD       = FRAMES;
  localparam int NODE_W     = $clog2(FRAMES + 1);
  // two full turns of the ring plus sentinel skips
  localparam int WALK_LIMIT = 2 * (FRAMES + 1) + 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                victim_valid;
    logic [PAGE_W-1:0]   victim_page;
  } page_answer_t;

  // shadow of the resident page ring
  logic [PAGE_W-1:0] frame_page [FRAMES];
  logic              frame_ref  [FRAMES];
  logic              frame_used [FRAMES];
  logic [NODE_W-1:0] ring_next  [FRAMES+1];
  logic [NODE_W-1:0] ring_prev  [FRAMES+1];
  logic [NODE_W-1:0] clock_hand;
  int                resident_pages;

  page_answer_t answers_q [$];

  // apply one command to the shadow ring and return the answer it earns
  function automatic page_answer_t predict_answer(logic [OP_W-1:0] op,
                                                  logic [PAGE_W-1:0] page);
    page_answer_t      ans;
    int                free_slot;
    int                step;
    logic              hit;
    logic [NODE_W-1:0] succ;
    logic [NODE_W-1:0] pred;
    logic [NODE_W-1:0] pos;
    ans.status       = STAT_OK;
    ans.victim_valid = 1'b0;
    ans.victim_page  = '0;
    case (op)
      OP_INSERT: begin
        if (resident_pages >= FRAMES) begin
          ans.status = STAT_FULL;
          return ans;
        end
        // lowest free slot, linked right after the hand
        free_slot = 0;
        while (frame_used[free_slot]) free_slot++;
        frame_page[free_slot] = page;
        frame_ref[free_slot]  = 1'b1;
        frame_used[free_slot] = 1'b1;
        succ                  = ring_next[clock_hand];
        ring_next[free_slot]  = succ;
        ring_prev[free_slot]  = clock_hand;
        ring_prev[succ]       = NODE_W'(free_slot);
        ring_next[clock_hand] = NODE_W'(free_slot);
        clock_hand            = NODE_W'(free_slot);
        resident_pages++;
      end
      OP_ACCESS: begin
        // every slot holding the page gets its reference bit
        hit = 1'b0;
        for (free_slot = 0; free_slot < FRAMES; free_slot++) begin
          if (frame_used[free_slot] && frame_page[free_slot] == page) begin
            frame_ref[free_slot] = 1'b1;
            hit = 1'b1;
          end
        end
        if (!hit) ans.status = STAT_ABSENT;
      end
      OP_VICTIM: begin
        if (resident_pages == 0) begin
          ans.status = STAT_EMPTY;
          return ans;
        end
        // sweep from one past the hand, giving referenced pages a second chance
        pos = ring_next[clock_hand];
        for (step = 0; step < WALK_LIMIT; step++) begin
          if (pos == NODE_W'(HEAD)) begin
            pos = ring_next[HEAD];
            continue;
          end
          if (!frame_ref[pos]) begin
            pred            = ring_prev[pos];
            succ            = ring_next[pos];
            ring_next[pred] = succ;
            ring_prev[succ] = pred;
            frame_used[pos] = 1'b0;
            frame_ref[pos]  = 1'b0;
            clock_hand      = pred;
            resident_pages--;
            ans.victim_valid = 1'b1;
            ans.victim_page  = frame_page[pos];
            return ans;
          end
          frame_ref[pos] = 1'b0;
          pos = ring_next[pos];
        end
        ans.status = STAT_EMPTY;
      end
      default: begin
        // spare operation code answers ok and changes nothing
      end
    endcase
    return ans;
  endfunction

  // predict on each accepted command, compare on each answer beat
  always @(posedge clk) begin : watch_beats
    page_answer_t got;
    page_answer_t want;
    int           idx;
    if (!rst_n) begin
      for (idx = 0; idx < FRAMES; idx++) begin
        frame_page[idx] = '0;
        frame_ref[idx]  = 1'b0;
        frame_used[idx] = 1'b0;
        ring_next[idx]  = '0;
        ring_prev[idx]  = '0;
      end
      ring_next[HEAD] = NODE_W'(HEAD);
      ring_prev[HEAD] = NODE_W'(HEAD);
      clock_hand      = NODE_W'(HEAD);
      resident_pages  = 0;
      mismatch_count  = 0;
      answers_q.delete();
    end else begin
      if (start && !busy)
        answers_q.push_back(predict_answer(in_operation, in_page_number));
      if (out_valid) begin
        got.status       = out_status;
        got.victim_valid = out_victim_valid;
        got.victim_page  = out_victim_page;
        if (answers_q.size() == 0) begin
          $error("answer beat with no command outstanding");
          mismatch_count++;
        end else begin
          want = answers_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.victim_valid !== want.victim_valid) begin
            $error("victim_valid: expected %0d, got %0d",
                   want.victim_valid, got.victim_valid);
            mismatch_count++;
          end
          if (got.victim_page !== want.victim_page) begin
            $error("victim_page: expected 0x%07h, got 0x%07h",
                   want.victim_page, got.victim_page);
            mismatch_count++;
          end
        end
      end
    end
    answers_due = answers_q.size();
  end

endmodule

FILE: tb/tb_clock_page_replacement_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clock_page_replacement_top
// drives inserts, accesses, victim requests and the spare operation into the
// clock replacement block: a directed opening over empty, full, duplicate and
// absent-page cases, then random phases that swing between filling and
// draining the ring over a small page pool; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_clock_page_replacement_top;
  import cpr_pkg::*;

  localparam int FRAMES       = FRAMES_DEF;
  localparam int PHASE_ITEMS  = 650;
  localparam int POOL_SIZE    = 20;
  localparam int MODE_SPAN    = 40;
  localparam int DRAIN_CYCLES = 4 * (FRAMES + 1) + 8;

  localparam logic [OP_W-1:0]   OP_SPARE = 2'd3;
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  // traffic mixes for the random part
  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_BALANCED = 2;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  logic [PAGE_W-1:0]   in_page_number;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_victim_valid;
  logic [PAGE_W-1:0]   out_victim_page;

  int                mismatch_count;
  int                answers_due;
  int                sender_idle_pct;
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  always #10 clk = ~clk;

  clock_page_replacement_top #(
    .FRAMES(FRAMES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_victim_valid(out_victim_valid),
    .out_victim_page (out_victim_page)
  );

  clock_page_replacement_checker #(
    .FRAMES(FRAMES)
  ) page_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_victim_valid(out_victim_valid),
    .out_victim_page (out_victim_page),
    .mismatch_count  (mismatch_count),
    .answers_due     (answers_due)
  );

  // one command beat, with random sender gaps ahead of it
  task automatic issue_command(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_operation   <= op;
    in_page_number <= page;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // mostly pool pages so accesses hit, sometimes any page at all
  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(99) < 80) return page_pool[$urandom_range(POOL_SIZE - 1)];
    return PAGE_W'($urandom);
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int               phase;
    int               n;
    int               mix;
    int               roll;
    int               insert_cut;
    int               access_cut;
    int               victim_cut;
    logic [OP_W-1:0]  op;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_INSERT;
    in_page_number  = '0;
    sender_idle_pct = 7;
    page_pool[0]    = '0;
    page_pool[1]    = PAGE_MAX;
    for (n = 2; n < POOL_SIZE; n++) page_pool[n] = PAGE_W'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring: absent access, empty victim, spare code
    issue_command(OP_ACCESS, '0);
    issue_command(OP_VICTIM, PAGE_MAX);
    issue_command(OP_SPARE, 27'h5555555);
    // extreme pages, duplicate insert, access hitting both duplicates, absent access
    issue_command(OP_INSERT, '0);
    issue_command(OP_INSERT, PAGE_MAX);
    issue_command(OP_INSERT, 27'h5555555);
    issue_command(OP_INSERT, 27'h5555555);
    issue_command(OP_ACCESS, 27'h5555555);
    issue_command(OP_ACCESS, 27'h2AAAAAA);
    // all referenced: sweep clears every bit before evicting
    issue_command(OP_VICTIM, '0);
    issue_command(OP_VICTIM, '0);
    // fill the ring, then overflow it
    for (n = 0; n < FRAMES - 2; n++) issue_command(OP_INSERT, PAGE_W'(n * 32'h0421_0843));
    issue_command(OP_INSERT, 27'h2AAAAAA);
    issue_command(OP_ACCESS, PAGE_MAX);
    issue_command(OP_VICTIM, '0);

    // random phases: sender gaps 7%, then 58%, then none
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 58 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % MODE_SPAN == 0) mix = $urandom_range(MIX_BALANCED);
        case (mix)
          MIX_FILL:  begin insert_cut = 55; access_cut = 85; victim_cut = 95; end
          MIX_DRAIN: begin insert_cut = 20; access_cut = 45; victim_cut = 95; end
          default:   begin insert_cut = 35; access_cut = 70; victim_cut = 95; end
        endcase
        roll = $urandom_range(99);
        if (roll < insert_cut)      op = OP_INSERT;
        else if (roll < access_cut) op = OP_ACCESS;
        else if (roll < victim_cut) op = OP_VICTIM;
        else                        op = OP_SPARE;
        issue_command(op, pick_page());
      end
    end
    start <= 1'b0;

    // let every outstanding answer arrive, then allow a quiet tail
    do @(negedge clk); while (answers_due != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && answers_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_links.sv
hw/rtl/cpr_tags.sv
hw/rtl/clock_page_replacement_top.sv
tb/clock_page_replacement_checker.sv
tb/tb_clock_page_replacement_top.sv
